@@ rtl/fvws_pkg.sv @@
// fvws_pkg: constants, types and helpers of the four-voice wavetable synth
`timescale 1ns / 1ps

package fvws_pkg;

   localparam int VOICE_COUNT       = 4;
   localparam int VOICE_TABLE_DEPTH = 512;

   localparam int TABLE_BYTES = 2048;
   localparam int TBL_AW      = 11;
   localparam int PHASE_W     = 24;
   localparam int INC_REGS    = 4;
   localparam int VCW         = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int DEPTH_W     = $clog2(VOICE_TABLE_DEPTH + 1);
   localparam int PPROD_W     = PHASE_W + DEPTH_W;
   localparam int MIX_W       = $clog2(VOICE_COUNT * 128) + 1;
   localparam int SCALE_W     = MIX_W + 9;
   localparam int SWEEP_W     = TBL_AW + 1;
   localparam int CSR_IDX_W   = 3;

   typedef enum logic [2:0] {
      CMD_TABLE_WRITE = 3'd0,
      CMD_TABLE_READ  = 3'd1,
      CMD_PHASE_LOAD  = 3'd2,
      CMD_PHASE_READ  = 3'd3,
      CMD_TICK        = 3'd4
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLUME = 3'd0,
      CSR_INC0   = 3'd1,
      CSR_INC1   = 3'd2,
      CSR_INC2   = 3'd3,
      CSR_INC3   = 3'd4
   } csr_idx_type;

   typedef enum logic [11:0] {
      S_CLEAR = 12'b000000000001,
      S_IDLE  = 12'b000000000010,
      S_DEC   = 12'b000000000100,
      S_RDW   = 12'b000000001000,
      S_ADV   = 12'b000000010000,
      S_MUL   = 12'b000000100000,
      S_RD    = 12'b000001000000,
      S_ACC   = 12'b000010000000,
      S_SCALE = 12'b000100000000,
      S_SAT   = 12'b001000000000,
      S_COPY  = 12'b010000000000,
      S_DONE  = 12'b100000000000
   } state_type;

   typedef struct packed {
      logic signed [15:0]   sample;
      logic [7:0]           rbyte;
      logic [PHASE_W-1:0]   phase;
      logic                 commit;
   } result_type;

   // first table entry of a voice
   function automatic logic [TBL_AW-1:0] voice_base(input logic [VCW-1:0] v);
      logic [31:0] t;
      t = 32'(v) * 32'(VOICE_TABLE_DEPTH);
      return t[TBL_AW-1:0];
   endfunction

endpackage

@@ rtl/four_voice_wavetable_synth.sv @@
// four_voice_wavetable_synth: table buffer, play table, voice phases and sequenced mixer
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  command, table address, voice, byte, phase
//   rsp      out        rsp_valid/rsp_stall  mixed sample, read byte, phase, committed
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// a table read waits on the buffer read port; write, phase load and phase read do not
// a tick advances and mixes each voice with a nonzero increment, then scales and saturates
// the committing write adds a copy into the play table over the single buffer read port
// after reset a clearing pass zeroes both tables before the first request
// a new request is taken while a finished result waits under rsp_stall
`timescale 1ns / 1ps

module four_voice_wavetable_synth
   import fvws_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_command,
   input  logic [TBL_AW-1:0]    req_table_address,
   input  logic [1:0]           req_voice_select,
   input  logic [7:0]           req_write_byte,
   input  logic [PHASE_W-1:0]   req_phase_load_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [15:0]   rsp_mixed_sample,
   output logic [7:0]           rsp_read_byte,
   output logic [PHASE_W-1:0]   rsp_phase_readback,
   output logic                 rsp_table_committed,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PHASE_W-1:0]   csr_data
);

   localparam logic signed [SCALE_W-1:0] SAT_MAX = SCALE_W'(32767);
   localparam logic signed [SCALE_W-1:0] SAT_MIN = SCALE_W'(-32768);

   logic [7:0] buf_mem  [TABLE_BYTES];
   logic [7:0] play_mem [TABLE_BYTES];

   state_type                 state_ff, state_in;
   logic [SWEEP_W-1:0]        sweep_ff, sweep_in;
   logic [TBL_AW-1:0]         wcount_ff, wcount_in;
   logic [PHASE_W-1:0]        phase_ff [VOICE_COUNT];
   logic [PHASE_W-1:0]        inc_ff [INC_REGS];
   logic [7:0]                volume_ff;
   logic [2:0]                cmd_ff;
   logic [TBL_AW-1:0]         addr_ff;
   logic [1:0]                sel_ff;
   logic [7:0]                byte_ff;
   logic [PHASE_W-1:0]        pload_ff;
   logic [VCW-1:0]            voice_ff, voice_in;
   logic [PHASE_W-1:0]        ph_ff, ph_in;
   logic [PPROD_W-1:0]        pprod_ff;
   logic signed [MIX_W-1:0]   mix_ff, mix_in;
   logic signed [SCALE_W-1:0] scaled_ff;
   result_type                res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   result_type                out_ff, out_in;
   logic [7:0]                buf_q_ff;
   logic [7:0]                play_q_ff;

   logic                      accept;
   logic [VCW-1:0]            ph_idx;
   logic [PHASE_W-1:0]        ph_rd;
   logic                      ph_we;
   logic [PHASE_W-1:0]        ph_wd;
   logic [PHASE_W-1:0]        vinc;
   logic                      last_voice;
   logic                      sel_ok;
   logic                      buf_we;
   logic [TBL_AW-1:0]         buf_wa, buf_ra;
   logic [7:0]                buf_wd;
   logic                      play_we;
   logic [TBL_AW-1:0]         play_wa, play_ra;
   logic [7:0]                play_wd;
   logic signed [7:0]         samp8;
   logic signed [SCALE_W-1:0] adj, quot;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mixed_sample    = out_ff.sample;
   assign rsp_read_byte       = out_ff.rbyte;
   assign rsp_phase_readback  = out_ff.phase;
   assign rsp_table_committed = out_ff.commit;

   // voice phase access, one address at a time
   assign sel_ok     = (32'(sel_ff) < 32'(VOICE_COUNT));
   assign ph_idx     = (state_ff == S_DEC) ? VCW'(sel_ff) : voice_ff;
   assign ph_rd      = phase_ff[ph_idx];
   assign vinc       = (32'(voice_ff) < 32'(INC_REGS)) ? inc_ff[2'(voice_ff)] : '0;
   assign last_voice = (voice_ff == VCW'(VOICE_COUNT - 1));

   // table ports
   assign buf_ra  = (state_ff == S_COPY) ? sweep_ff[TBL_AW-1:0] : addr_ff;
   assign play_ra = TBL_AW'({1'b0, voice_base(voice_ff)} + (TBL_AW + 1)'(pprod_ff >> PHASE_W));

   assign samp8 = $signed({~play_q_ff[7], play_q_ff[6:0]});
   assign adj   = scaled_ff + (scaled_ff[SCALE_W-1] ? SCALE_W'(3) : '0);
   assign quot  = adj >>> 2;

   always_comb begin
      buf_we  = 1'b0;
      buf_wa  = addr_ff;
      buf_wd  = byte_ff;
      play_we = 1'b0;
      play_wa = TBL_AW'(sweep_ff - 1'b1);
      play_wd = buf_q_ff;
      if (state_ff == S_CLEAR) begin
         buf_we  = 1'b1;
         buf_wa  = sweep_ff[TBL_AW-1:0];
         buf_wd  = '0;
         play_we = 1'b1;
         play_wa = sweep_ff[TBL_AW-1:0];
         play_wd = '0;
      end else if (state_ff == S_DEC && cmd_ff == CMD_TABLE_WRITE) begin
         buf_we = 1'b1;
      end else if (state_ff == S_COPY && sweep_ff != '0) begin
         play_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_wa] <= buf_wd;
      end
      buf_q_ff <= buf_mem[buf_ra];
   end

   always_ff @(posedge clock) begin
      if (play_we) begin
         play_mem[play_wa] <= play_wd;
      end
      play_q_ff <= play_mem[play_ra];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      wcount_in    = wcount_ff;
      voice_in     = voice_ff;
      ph_in        = ph_ff;
      mix_in       = mix_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_in       = out_ff;
      ph_we        = 1'b0;
      ph_wd        = ph_rd + vinc;
      case (state_ff)
         S_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff[TBL_AW-1:0] == TBL_AW'(TABLE_BYTES - 1)) begin
               sweep_in = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            res_in   = '0;
            state_in = S_DONE;
            case (cmd_ff)
               CMD_TABLE_WRITE: begin
                  wcount_in = wcount_ff + 1'b1;
                  if (wcount_ff == TBL_AW'(TABLE_BYTES - 1)) begin
                     res_in.commit = 1'b1;
                     sweep_in      = '0;
                     state_in      = S_COPY;
                  end
               end
               CMD_TABLE_READ: begin
                  state_in = S_RDW;
               end
               CMD_PHASE_LOAD: begin
                  ph_we = sel_ok;
                  ph_wd = pload_ff;
               end
               CMD_PHASE_READ: begin
                  if (sel_ok) begin
                     res_in.phase = ph_rd;
                  end
               end
               CMD_TICK: begin
                  voice_in = '0;
                  mix_in   = '0;
                  state_in = S_ADV;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_RDW: begin
            res_in.rbyte = buf_q_ff;
            state_in     = S_DONE;
         end
         S_ADV: begin
            if (vinc != '0) begin
               ph_we    = 1'b1;
               ph_in    = ph_wd;
               state_in = S_MUL;
            end else if (last_voice) begin
               state_in = S_SCALE;
            end else begin
               voice_in = voice_ff + 1'b1;
            end
         end
         S_MUL: begin
            state_in = S_RD;
         end
         S_RD: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            mix_in = mix_ff + MIX_W'(samp8);
            if (last_voice) begin
               state_in = S_SCALE;
            end else begin
               voice_in = voice_ff + 1'b1;
               state_in = S_ADV;
            end
         end
         S_SCALE: begin
            state_in = S_SAT;
         end
         S_SAT: begin
            if (quot > SAT_MAX) begin
               res_in.sample = 16'sh7fff;
            end else if (quot < SAT_MIN) begin
               res_in.sample = -16'sh8000;
            end else begin
               res_in.sample = quot[15:0];
            end
            state_in = S_DONE;
         end
         S_COPY: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SWEEP_W'(TABLE_BYTES)) begin
               sweep_in = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         wcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         volume_ff    <= '0;
         for (int i = 0; i < VOICE_COUNT; i++) begin
            phase_ff[i] <= '0;
         end
         for (int i = 0; i < INC_REGS; i++) begin
            inc_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         wcount_ff    <= wcount_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ph_we) begin
            phase_ff[ph_idx] <= ph_wd;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VOLUME: volume_ff <= csr_data[7:0];
               CSR_INC0:   inc_ff[0] <= csr_data;
               CSR_INC1:   inc_ff[1] <= csr_data;
               CSR_INC2:   inc_ff[2] <= csr_data;
               CSR_INC3:   inc_ff[3] <= csr_data;
               default:    ;
            endcase
         end
      end
   end

   // request and datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         addr_ff  <= req_table_address;
         sel_ff   <= req_voice_select;
         byte_ff  <= req_write_byte;
         pload_ff <= req_phase_load_value;
      end
      voice_ff  <= voice_in;
      ph_ff     <= ph_in;
      mix_ff    <= mix_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
      pprod_ff  <= PPROD_W'(ph_ff) * PPROD_W'(VOICE_TABLE_DEPTH);
      scaled_ff <= SCALE_W'(mix_ff) * SCALE_W'($signed({1'b0, volume_ff}));
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_mul_after_adv: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> $past(state_ff) == S_ADV)
      else $error("phase multiply without phase advance");

   a_copy_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COPY |-> wcount_ff == '0 && sweep_ff <= SWEEP_W'(TABLE_BYTES))
      else $error("table copy out of step with write count");

   a_sample_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mixed_sample != '0 |->
         rsp_read_byte == '0 && rsp_phase_readback == '0 && !rsp_table_committed)
      else $error("tick result mixed with other fields");

   a_commit_copy: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && res_ff.commit |-> $past(state_ff) == S_COPY
         || $past(state_ff) == S_DONE)
      else $error("commit reported without table copy");

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for the four-voice wavetable synth, predicted per request
`timescale 1ns / 1ps

module tb_top;
   import fvws_pkg::*;

   localparam logic [2:0]           CMD_RSVD_FIRST  = 3'd5;
   localparam logic [2:0]           CMD_RSVD_LAST   = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_RSVD_FIRST  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RSVD_LAST   = 3'd7;
   localparam logic [PHASE_W-1:0]   PHASE_MAX       = {PHASE_W{1'b1}};
   localparam logic [TBL_AW-1:0]    ADDR_MAX        = {TBL_AW{1'b1}};
   localparam int                   RANDOM_REQUESTS = 1050;
   localparam int                   RANDOM_PHASES   = 5;
   localparam int                   WATCHDOG_LIMIT  = 12000;
   localparam int                   DRAIN_CYCLES    = 40;
   localparam int                   LONG_HOLD       = 600;
   localparam int                   HOLD_AT_RESULT  = 2600;
   localparam int                   MAX_REPORTS     = 50;

   typedef struct packed {
      logic [2:0]         command;
      logic [TBL_AW-1:0]  address;
      logic [1:0]         voice;
      logic [7:0]         wbyte;
      logic [PHASE_W-1:0] phase;
   } bus_req_type;

   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_LIGHT,
      FLOW_HEAVY,
      FLOW_PERIODIC
   } flow_mode_type;

   logic                 clock                = 1'b0;
   logic                 reset                = 1'b1;
   logic                 req_valid            = 1'b0;
   logic                 req_stall;
   logic [2:0]           req_command          = '0;
   logic [TBL_AW-1:0]    req_table_address    = '0;
   logic [1:0]           req_voice_select     = '0;
   logic [7:0]           req_write_byte       = '0;
   logic [PHASE_W-1:0]   req_phase_load_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall            = 1'b0;
   logic signed [15:0]   rsp_mixed_sample;
   logic [7:0]           rsp_read_byte;
   logic [PHASE_W-1:0]   rsp_phase_readback;
   logic                 rsp_table_committed;
   logic                 csr_valid            = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index            = '0;
   logic [PHASE_W-1:0]   csr_data             = '0;

   // shadow copy of the synth state
   logic [7:0]           shadow_buffer [TABLE_BYTES];
   logic [7:0]           shadow_play   [TABLE_BYTES];
   logic [PHASE_W-1:0]   shadow_phase  [VOICE_COUNT];
   logic [PHASE_W-1:0]   shadow_inc    [INC_REGS];
   logic [7:0]           shadow_volume;
   int                   writes_since_commit;

   bus_req_type          bus_requests [$];
   result_type           owed_results [$];
   bus_req_type          offered;
   int                   writes_queued;
   int                   burst_left;
   int                   gap_left;
   int                   results_seen;
   int                   mismatches;
   int                   quiet_cycles;
   int                   hold_left;
   logic                 hold_done;
   int                   mode_left;
   flow_mode_type        flow_mode;

   four_voice_wavetable_synth u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_table_address    (req_table_address),
      .req_voice_select     (req_voice_select),
      .req_write_byte       (req_write_byte),
      .req_phase_load_value (req_phase_load_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_mixed_sample     (rsp_mixed_sample),
      .rsp_read_byte        (rsp_read_byte),
      .rsp_phase_readback   (rsp_phase_readback),
      .rsp_table_committed  (rsp_table_committed),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic result_type synth_result(input bus_req_type r);
      result_type res;
      int         mix;
      int         scaled;
      logic [63:0] spot;
      res = '0;
      case (r.command)
         CMD_TABLE_WRITE: begin
            shadow_buffer[r.address] = r.wbyte;
            writes_since_commit++;
            if (writes_since_commit >= TABLE_BYTES) begin
               for (int i = 0; i < TABLE_BYTES; i++) shadow_play[i] = shadow_buffer[i];
               writes_since_commit = 0;
               res.commit = 1'b1;
            end
         end
         CMD_TABLE_READ: begin
            res.rbyte = shadow_buffer[r.address];
         end
         CMD_PHASE_LOAD: begin
            if (r.voice < VOICE_COUNT) shadow_phase[r.voice] = r.phase;
         end
         CMD_PHASE_READ: begin
            if (r.voice < VOICE_COUNT) res.phase = shadow_phase[r.voice];
         end
         CMD_TICK: begin
            mix = 0;
            for (int v = 0; v < VOICE_COUNT; v++) begin
               if (v < INC_REGS && shadow_inc[v] != '0) begin
                  shadow_phase[v] = shadow_phase[v] + shadow_inc[v];
                  spot = 64'(v) * 64'(VOICE_TABLE_DEPTH)
                       + ((64'(shadow_phase[v]) * 64'(VOICE_TABLE_DEPTH)) >> PHASE_W);
                  // offset binary to signed
                  mix += int'(shadow_play[spot[TBL_AW-1:0]]) - 128;
               end
            end
            scaled = (mix * int'(shadow_volume)) / 4;
            if (scaled > 32767) scaled = 32767;
            if (scaled < -32768) scaled = -32768;
            res.sample = scaled[15:0];
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch at response %0d: %s", results_seen, msg);
   endtask

   task automatic queue_request(input logic [2:0] cmd, input logic [TBL_AW-1:0] addr,
                                input logic [1:0] voice, input logic [7:0] wbyte,
                                input logic [PHASE_W-1:0] phase);
      bus_req_type r;
      r.command = cmd;
      r.address = addr;
      r.voice   = voice;
      r.wbyte   = wbyte;
      r.phase   = phase;
      bus_requests.insert(bus_requests.size(), r);
      if (cmd == CMD_TABLE_WRITE) writes_queued++;
   endtask

   task automatic queue_random_request();
      logic [2:0]         cmd;
      logic [PHASE_W-1:0] phase;
      int                 pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) cmd = CMD_TICK;
      else if (pick < 55) cmd = CMD_TABLE_WRITE;
      else if (pick < 68) cmd = CMD_TABLE_READ;
      else if (pick < 78) cmd = CMD_PHASE_LOAD;
      else if (pick < 93) cmd = CMD_PHASE_READ;
      else cmd = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
      case ($urandom_range(0, 5))
         0: phase = PHASE_W'(PHASE_MAX - $urandom_range(0, 255));
         1: phase = PHASE_W'($urandom_range(0, 255));
         default: phase = PHASE_W'($urandom_range(0, PHASE_MAX));
      endcase
      queue_request(cmd, TBL_AW'($urandom_range(0, ADDR_MAX)), 2'($urandom_range(0, 3)),
                    8'($urandom_range(0, 255)), phase);
   endtask

   // enough writes to reach the next commit, to consecutive addresses from a random start
   task automatic queue_table_load();
      int         first;
      int         count;
      logic [7:0] b;
      first = $urandom_range(0, ADDR_MAX);
      count = TABLE_BYTES - (writes_queued % TABLE_BYTES);
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(0, 7))
            0: b = 8'h00;
            1: b = 8'hff;
            default: b = 8'($urandom_range(0, 255));
         endcase
         queue_request(CMD_TABLE_WRITE, TBL_AW'((first + k) % TABLE_BYTES),
                       2'($urandom_range(0, 3)), b, PHASE_W'($urandom_range(0, PHASE_MAX)));
         if ($urandom_range(0, 15) == 0) begin
            queue_request(CMD_TABLE_READ, TBL_AW'($urandom_range(0, ADDR_MAX)),
                          2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          PHASE_W'($urandom_range(0, PHASE_MAX)));
         end
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [PHASE_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_VOLUME: shadow_volume = data[7:0];
         CSR_INC0, CSR_INC1, CSR_INC2, CSR_INC3: shadow_inc[2'(idx - CSR_INC0)] = data;
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   function automatic logic [PHASE_W-1:0] pick_increment();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return PHASE_MAX;
         2: return PHASE_W'($urandom_range(1, 64)) << 15;
         3: return PHASE_W'($urandom_range(1, 4096));
         default: return PHASE_W'($urandom_range(1, PHASE_MAX));
      endcase
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (bus_requests.size() != 0 || req_valid || owed_results.size() != 0);
   endtask

   initial begin : stimulus
      logic [7:0] volume;
      for (int i = 0; i < TABLE_BYTES; i++) begin
         shadow_buffer[i] = '0;
         shadow_play[i]   = '0;
      end
      for (int v = 0; v < VOICE_COUNT; v++) shadow_phase[v] = '0;
      for (int v = 0; v < INC_REGS; v++) shadow_inc[v] = '0;
      shadow_volume       = '0;
      writes_since_commit = 0;
      writes_queued       = 0;
      mismatches          = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = CSR_RSVD_FIRST; i <= CSR_RSVD_LAST; i++) csr_write(CSR_IDX_W'(i), PHASE_MAX);
      csr_write(CSR_VOLUME, 24'd255);
      csr_write(CSR_INC0, 24'h008000);
      csr_write(CSR_INC1, PHASE_MAX);
      csr_write(CSR_INC2, '0);
      csr_write(CSR_INC3, 24'h123457);

      queue_request(CMD_TABLE_WRITE, '0, 2'd0, 8'hff, '0);
      queue_request(CMD_TABLE_WRITE, ADDR_MAX, 2'd0, 8'h00, '0);
      queue_request(CMD_TABLE_WRITE, 11'h555, 2'd0, 8'haa, '0);
      queue_request(CMD_TABLE_WRITE, 11'h2aa, 2'd0, 8'h55, '0);
      queue_request(CMD_TABLE_READ, '0, 2'd0, 8'h00, '0);
      queue_request(CMD_TABLE_READ, ADDR_MAX, 2'd0, 8'h00, '0);
      queue_request(CMD_TABLE_READ, 11'h555, 2'd0, 8'h00, '0);
      queue_request(CMD_TABLE_READ, 11'h2aa, 2'd0, 8'h00, '0);
      queue_request(CMD_TABLE_READ, 11'h400, 2'd0, 8'h00, '0);
      queue_request(CMD_PHASE_LOAD, '0, 2'd0, 8'h00, PHASE_MAX);
      queue_request(CMD_PHASE_LOAD, '0, 2'd1, 8'h00, '0);
      queue_request(CMD_PHASE_LOAD, '0, 2'd2, 8'h00, 24'h800000);
      queue_request(CMD_PHASE_LOAD, '0, 2'd3, 8'h00, 24'h7fffff);
      for (int v = 0; v < VOICE_COUNT; v++) queue_request(CMD_PHASE_READ, '0, 2'(v), 8'h00, '0);
      repeat (3) queue_request(CMD_TICK, '0, 2'd0, 8'h00, '0);
      queue_request(CMD_PHASE_READ, '0, 2'd0, 8'h00, '0);
      // reserved commands with every other field at its top
      for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++) begin
         queue_request(3'(c), ADDR_MAX, 2'd3, 8'hff, PHASE_MAX);
      end
      queue_request(CMD_TICK, ADDR_MAX, 2'd3, 8'hff, PHASE_MAX);

      wait_idle();
      queue_table_load();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         case (p)
            0: volume = 8'd255;
            1: volume = 8'd0;
            2: volume = 8'd1;
            default: volume = 8'($urandom_range(0, 255));
         endcase
         csr_write(CSR_VOLUME, {16'd0, volume});
         csr_write(CSR_INC0, pick_increment());
         csr_write(CSR_INC1, pick_increment());
         csr_write(CSR_INC2, pick_increment());
         csr_write(CSR_INC3, pick_increment());
         repeat (RANDOM_REQUESTS / RANDOM_PHASES) queue_random_request();
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   always @(posedge clock) begin : driver
      bus_req_type nxt;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            owed_results.insert(owed_results.size(), synth_result(offered));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (bus_requests.size() != 0) begin
               nxt = bus_requests.pop_front();
               offered              <= nxt;
               req_valid            <= 1'b1;
               req_command          <= nxt.command;
               req_table_address    <= nxt.address;
               req_voice_select     <= nxt.voice;
               req_write_byte       <= nxt.wbyte;
               req_phase_load_value <= nxt.phase;
               if (burst_left <= 1) begin
                  burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(150, 300)
                                                            : $urandom_range(1, 24);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
         mode_left <= 0;
         flow_mode <= FLOW_FREE;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
         // long back-pressure so the synth fills up and stalls its input
         hold_done <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            flow_mode <= flow_mode_type'(2'($urandom_range(0, 3)));
            mode_left <= $urandom_range(32, 256);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (flow_mode)
            FLOW_FREE:   rsp_stall <= 1'b0;
            FLOW_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
            FLOW_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((mode_left % 5) < 2);
         endcase
      end
   end

   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         results_seen <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (owed_results.size() == 0) begin
            report("response with no request outstanding");
         end else begin
            want = owed_results.pop_front();
            if (rsp_mixed_sample !== want.sample)
               report($sformatf("mixed_sample got %0d expected %0d",
                                rsp_mixed_sample, want.sample));
            if (rsp_read_byte !== want.rbyte)
               report($sformatf("read_byte got %0h expected %0h", rsp_read_byte, want.rbyte));
            if (rsp_phase_readback !== want.phase)
               report($sformatf("phase_readback got %0h expected %0h",
                                rsp_phase_readback, want.phase));
            if (rsp_table_committed !== want.commit)
               report($sformatf("table_committed got %0b expected %0b",
                                rsp_table_committed, want.commit));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                   (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

@@ files.f @@
rtl/fvws_pkg.sv
rtl/four_voice_wavetable_synth.sv
tb/tb_top.sv
